[design/modular_exponentiation_macros.svh]
// Assertion macros for the modular exponentiation block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
`ifndef SYNTHESIS
`define MX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MX_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MX_ASSERT(label, clk, rst_n, prop)
`define MX_ASSERT_RST(label, clk, prop)
`endif
`endif

[design/modexp_pkg.sv]
// Shared constants for the modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps
package modexp_pkg;
    // Job classes decided by the front end
    localparam logic [1:0] KIND_ERR  = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;
endpackage

[design/modexp_front.sv]
// Front end: accepts requests, classifies them and reduces the base modulo the modulus.
// Depends on modexp_pkg and modular_exponentiation_macros.svh.
`timescale 1ns / 1ps
`include "modular_exponentiation_macros.svh"
module modexp_front #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [W-1:0]   base,
    input  logic [W-2:0]   exponent,
    input  logic [W-2:0]   modulus,
    output logic           q_valid,
    input  logic           q_ready,
    output logic [1:0]     q_kind,
    output logic [W-2:0]   q_base,
    output logic [W-2:0]   q_exp,
    output logic [W-2:0]   q_mod
);
    localparam int CW = $clog2(W + 1);
    logic           busy_reg;
    logic           out_reg;
    logic           neg_reg;
    logic [W-1:0]   mag_reg;
    logic [W-1:0]   rem_reg;
    logic [CW-1:0]  cnt_reg;
    logic [1:0]     kind_reg;
    logic [W-2:0]   exp_reg;
    logic [W-2:0]   mod_reg;
    logic [W-2:0]   res_reg;
    logic [W:0]     trial;
    logic [W-1:0]   rem_sh;

    assign in_ready = !busy_reg && !out_reg;
    assign q_valid  = out_reg;
    assign q_kind   = kind_reg;
    assign q_base   = res_reg;
    assign q_exp    = exp_reg;
    assign q_mod    = mod_reg;
    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg[W-2:0], mag_reg[W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, mod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (in_valid && in_ready)
        begin
            exp_reg <= exponent;
            mod_reg <= modulus;
            neg_reg <= base[W-1];
            mag_reg <= base[W-1] ? (~base + 1'b1) : base;
            rem_reg <= '0;
            cnt_reg <= CW'(W);
            res_reg <= '0;
            if (modulus == '0)
            begin
                kind_reg <= modexp_pkg::KIND_ERR;
                out_reg  <= 1'b1;
            end
            else if (modulus == (W-1)'(1))
            begin
                kind_reg <= modexp_pkg::KIND_ZERO;
                out_reg  <= 1'b1;
            end
            else
            begin
                kind_reg <= modexp_pkg::KIND_RUN;
                busy_reg <= 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_reg <= trial[W] ? rem_sh : trial[W-1:0];
                mag_reg <= {mag_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                if (neg_reg && rem_reg != '0)
                    res_reg <= mod_reg - rem_reg[W-2:0];
                else
                    res_reg <= rem_reg[W-2:0];
                busy_reg <= 1'b0;
                out_reg  <= 1'b1;
            end
        end
        else if (out_reg && q_ready)
        begin
            out_reg <= 1'b0;
        end
    end

    `MX_ASSERT(a_front_excl, clk, rst_n, !(busy_reg && out_reg))
    `MX_ASSERT(a_front_rem, clk, rst_n, busy_reg |-> (rem_reg < {1'b0, mod_reg}))
    `MX_ASSERT(a_front_hold, clk, rst_n, (out_reg && !q_ready) |=> out_reg)
endmodule

[design/modexp_back.sv]
// Back end: square-and-multiply with a bit-serial modular multiplier.
// Depends on modexp_pkg and modular_exponentiation_macros.svh.
`timescale 1ns / 1ps
`include "modular_exponentiation_macros.svh"
module modexp_back #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  logic [1:0]     q_kind,
    input  logic [W-2:0]   q_base,
    input  logic [W-2:0]   q_exp,
    input  logic [W-2:0]   q_mod,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [W-2:0]   residue,
    output logic           error
);
    localparam int N  = W - 1;
    localparam int CW = $clog2(N + 1);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic [2:0]     st_reg;
    logic [N-1:0]   acc_reg;
    logic [N-1:0]   b_reg;
    logic [N-1:0]   e_reg;
    logic [N-1:0]   m_reg;
    logic [N-1:0]   r_reg;
    logic [N-1:0]   mb_reg;     // multiplier operand being scanned
    logic [CW-1:0]  ebit_reg;
    logic [CW-1:0]  mbit_reg;
    logic           err_reg;
    logic [N:0]     dbl;
    logic [N-1:0]   dbl_r;
    logic [N:0]     sum;
    logic [N-1:0]   step_r;
    logic [N-1:0]   mul_a;

    assign q_ready   = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);
    assign residue   = acc_reg;
    assign error     = err_reg;
    assign mul_a     = (st_reg == ST_SQ) ? acc_reg : b_reg;

    // one shift-and-add step of r = r*2 + bit*a (mod m)
    always_comb
    begin
        dbl   = {r_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, m_reg}) ? N'(dbl - {1'b0, m_reg}) : dbl[N-1:0];
        sum   = {1'b0, dbl_r} + (mb_reg[N-1] ? {1'b0, mul_a} : '0);
        step_r = (sum >= {1'b0, m_reg}) ? N'(sum - {1'b0, m_reg}) : sum[N-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            ebit_reg <= '0;
            mbit_reg <= '0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        err_reg  <= (q_kind == modexp_pkg::KIND_ERR);
                        b_reg    <= q_base;
                        e_reg    <= q_exp;
                        m_reg    <= q_mod;
                        ebit_reg <= CW'(N);
                        if (q_kind == modexp_pkg::KIND_RUN)
                        begin
                            acc_reg <= N'(1);
                            st_reg  <= ST_SQ;
                            r_reg   <= '0;
                            mb_reg  <= N'(1);
                            mbit_reg <= CW'(N);
                        end
                        else
                        begin
                            acc_reg <= '0;
                            st_reg  <= ST_OUT;
                        end
                    end
                end
                ST_SQ, ST_MUL:
                begin
                    if (ebit_reg == '0)
                        st_reg <= ST_OUT;
                    else if (mbit_reg != '0)
                    begin
                        r_reg    <= step_r;
                        mb_reg   <= {mb_reg[N-2:0], 1'b0};
                        mbit_reg <= mbit_reg - 1'b1;
                    end
                    else
                    begin
                        acc_reg <= r_reg;
                        r_reg   <= '0;
                        mbit_reg <= CW'(N);
                        if (st_reg == ST_SQ && e_reg[N-1])
                        begin
                            st_reg <= ST_MUL;
                            mb_reg <= r_reg;
                        end
                        else
                        begin
                            e_reg    <= {e_reg[N-2:0], 1'b0};
                            ebit_reg <= ebit_reg - 1'b1;
                            st_reg   <= ST_SQ;
                            mb_reg   <= r_reg;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                        st_reg <= ST_IDLE;
                end
                default:
                    st_reg <= ST_IDLE;
            endcase
        end
    end

    `MX_ASSERT(a_back_acc, clk, rst_n, (st_reg == ST_SQ) |-> (acc_reg < m_reg))
    `MX_ASSERT(a_back_r, clk, rst_n, (st_reg == ST_MUL) |-> (r_reg < m_reg))
    `MX_ASSERT(a_back_out, clk, rst_n, (out_valid && !out_ready) |=> $stable(residue))
endmodule

[design/modular_exponentiation.sv]
// Modular exponentiation: front end reduces the base, back end runs
// square-and-multiply with a bit-serial modular multiplier; the front end reduces
// the next base while the back end runs, and one request waits in the front end.
// Reset clears all handshake state asynchronously; no memories need clearing.
`timescale 1ns / 1ps
module modular_exponentiation #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] base,
    input  logic [DATA_WIDTH-2:0] exponent,
    input  logic [DATA_WIDTH-2:0] modulus,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-2:0] residue,
    output logic                  error
);
    logic                  q_valid;
    logic                  q_ready;
    logic [1:0]            q_kind;
    logic [DATA_WIDTH-2:0] q_base;
    logic [DATA_WIDTH-2:0] q_exp;
    logic [DATA_WIDTH-2:0] q_mod;

    modexp_front #(.W(DATA_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .base(base), .exponent(exponent), .modulus(modulus),
        .q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind),
        .q_base(q_base), .q_exp(q_exp), .q_mod(q_mod)
    );

    modexp_back #(.W(DATA_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_kind(q_kind), .q_base(q_base), .q_exp(q_exp), .q_mod(q_mod),
        .out_valid(out_valid), .out_ready(out_ready),
        .residue(residue), .error(error)
    );
endmodule
